// ===== hw/rtl/mmau_pkg.sv =====
`timescale 1ns / 1ps

package mmau_pkg;

  localparam int MAX_DIM_DEF   = 8;
  localparam int FRAC_BITS_DEF = 16;

  localparam int IDX_W     = 3;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 2;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int ACC_W     = 68;

  localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD_C = 2'd2;
  localparam logic [OP_W-1:0] OP_START  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCUMULATE = 2'd3;

  typedef struct packed {
    logic load_c;
    logic use_c;
    logic mul;
    logic acc;
  } mac_ctl_t;

endpackage

// ===== hw/rtl/mmau_ram.sv =====
`timescale 1ns / 1ps

module mmau_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/mmau_store.sv =====
`timescale 1ns / 1ps

module mmau_store #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [DEPTH-1:0] written;
  logic             written_q;
  logic [WIDTH-1:0] ram_q;

  mmau_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      written_q <= written[raddr];
    end
  end

  // unwritten entries read as zero
  assign rdata = written_q ? ram_q : '0;

endmodule

// ===== hw/rtl/mmau_mac.sv =====
`timescale 1ns / 1ps

module mmau_mac #(
  parameter int FRAC_BITS = mmau_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  mmau_pkg::mac_ctl_t                  ctl,
  input  logic signed [mmau_pkg::DATA_W-1:0]  a_value,
  input  logic signed [mmau_pkg::DATA_W-1:0]  b_value,
  input  logic signed [mmau_pkg::DATA_W-1:0]  c_value,
  output logic        [mmau_pkg::DATA_W-1:0]  res,
  output logic                                sat
);

  localparam int AW = mmau_pkg::ACC_W;
  localparam int DW = mmau_pkg::DATA_W;

  logic signed [2*DW-1:0] prod;
  logic signed [AW-1:0]   acc;
  logic signed [AW-1:0]   c_ext;
  logic signed [AW-1:0]   prod_ext;
  logic signed [AW-1:0]   shifted;
  logic [AW-DW:0]         upper;
  logic                   fits;

  assign c_ext    = AW'(c_value);
  assign prod_ext = AW'(prod);

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod <= a_value * b_value;
    end
    if (ctl.load_c) begin
      acc <= ctl.use_c ? (c_ext <<< FRAC_BITS) : '0;
    end else if (ctl.acc) begin
      acc <= acc + prod_ext;
    end
  end

  // floor shift, then clip to the 32-bit range
  assign shifted = acc >>> FRAC_BITS;
  assign upper   = shifted[AW-1:DW-1];
  assign fits    = (&upper) | ~(|upper);

  always_comb begin
    if (fits) begin
      res = shifted[DW-1:0];
    end else if (shifted[AW-1]) begin
      res = {1'b1, {(DW-1){1'b0}}};
    end else begin
      res = {1'b0, {(DW-1){1'b1}}};
    end
    sat = ~fits;
  end

endmodule

// ===== hw/rtl/matrix_multiply_accumulate_unit.sv =====
`timescale 1ns / 1ps

// Fixed-point matrix multiply-accumulate, signed elements with FRAC_BITS
// fraction bits.
// Input channel (in_valid/in_ready): each transaction either loads one
// element of A, B or C at (row_index, col_index), or starts a run that
// computes C = C + A*B (accumulate = 1) or C = A*B (accumulate = 0).
// Output channel (out_valid/out_ready): one transaction per result element,
// column outer and row inner, with last on the final element. Each result is
// also written back into the C store.
// Configuration: write_enable, reg_index and write_data set the sizes and
// the accumulate mode; write only while the block is idle.
// A start runs one shared 32x32 multiplier and a 68-bit accumulator; each
// result element goes through these steps in order: C read, C load, then
// read, multiply and add for each inner term, then result.
// in_ready is low for the whole run. A result waits in the output register
// while out_ready is low; the run holds before the next result meanwhile.
// Reset clears the stores to zero and the sizes to 8, accumulate to 1.

module matrix_multiply_accumulate_unit #(
  parameter int MAX_DIM   = mmau_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = mmau_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic        [mmau_pkg::OP_W-1:0]       operation,
  input  logic        [mmau_pkg::IDX_W-1:0]      row_index,
  input  logic        [mmau_pkg::IDX_W-1:0]      col_index,
  input  logic signed [mmau_pkg::DATA_W-1:0]     element_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic        [mmau_pkg::IDX_W-1:0]      out_row,
  output logic        [mmau_pkg::IDX_W-1:0]      out_col,
  output logic signed [mmau_pkg::DATA_W-1:0]     out_value,
  output logic                                   saturated,
  output logic                                   last,
  input  logic                                   write_enable,
  input  logic        [mmau_pkg::CFG_IDX_W-1:0]  reg_index,
  input  logic        [mmau_pkg::CFG_W-1:0]      write_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = mmau_pkg::IDX_W;
  localparam int DW    = mmau_pkg::DATA_W;
  localparam int CW    = mmau_pkg::CFG_W;

  localparam logic [IW:0] DIM_LIM = (IW + 1)'(MAX_DIM);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CRD  = 3'd1;
  localparam logic [2:0] S_CLD  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(r) + AW'(c) * AW'(MAX_DIM);
  endfunction

  function automatic logic [IW-1:0] dim_last(input logic [CW-1:0] v);
    logic [IW-1:0] d;
    if (v == '0) begin
      d = '0;
    end else if (v > CW'(MAX_DIM)) begin
      d = IW'(MAX_DIM - 1);
    end else begin
      d = IW'(v - CW'(1));
    end
    return d;
  endfunction

  logic [CW-1:0] rows_a;
  logic [CW-1:0] inner_size;
  logic [CW-1:0] cols_b;
  logic          accumulate;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [IW-1:0] i_cnt;
  logic [IW-1:0] j_cnt;
  logic [IW-1:0] p_cnt;
  logic [IW-1:0] m_last;
  logic [IW-1:0] k_last;
  logic [IW-1:0] n_last;

  logic          accept;
  logic          in_range;
  logic          out_load;
  logic [AW-1:0] load_addr;
  logic          a_we;
  logic          b_we;
  logic          c_we;
  logic [AW-1:0] c_waddr;
  logic [DW-1:0] c_wdata;
  logic [DW-1:0] a_rd;
  logic [DW-1:0] b_rd;
  logic [DW-1:0] c_rd;
  logic [DW-1:0] mac_res;
  logic          mac_sat;

  mmau_pkg::mac_ctl_t ctl;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign in_range  = ({1'b0, row_index} < DIM_LIM) && ({1'b0, col_index} < DIM_LIM);
  assign load_addr = addr_of(row_index, col_index);
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);

  assign a_we    = accept && in_range && (operation == mmau_pkg::OP_LOAD_A);
  assign b_we    = accept && in_range && (operation == mmau_pkg::OP_LOAD_B);
  assign c_we    = out_load || (accept && in_range && (operation == mmau_pkg::OP_LOAD_C));
  assign c_waddr = out_load ? addr_of(i_cnt, j_cnt) : load_addr;
  assign c_wdata = out_load ? mac_res : element_value;

  mmau_store #(.WIDTH(DW), .DEPTH(DEPTH)) u_a_store (
    .clk  (clk),
    .rst  (rst),
    .we   (a_we),
    .waddr(load_addr),
    .wdata(element_value),
    .raddr(addr_of(i_cnt, p_cnt)),
    .rdata(a_rd)
  );

  mmau_store #(.WIDTH(DW), .DEPTH(DEPTH)) u_b_store (
    .clk  (clk),
    .rst  (rst),
    .we   (b_we),
    .waddr(load_addr),
    .wdata(element_value),
    .raddr(addr_of(p_cnt, j_cnt)),
    .rdata(b_rd)
  );

  mmau_store #(.WIDTH(DW), .DEPTH(DEPTH)) u_c_store (
    .clk  (clk),
    .rst  (rst),
    .we   (c_we),
    .waddr(c_waddr),
    .wdata(c_wdata),
    .raddr(addr_of(i_cnt, j_cnt)),
    .rdata(c_rd)
  );

  always_comb begin
    ctl.load_c = (state == S_CLD);
    ctl.use_c  = accumulate;
    ctl.mul    = (state == S_MUL);
    ctl.acc    = (state == S_ACC);
  end

  mmau_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk    (clk),
    .ctl    (ctl),
    .a_value(a_rd),
    .b_value(b_rd),
    .c_value(c_rd),
    .res    (mac_res),
    .sat    (mac_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a     <= CW'(8);
      inner_size <= CW'(8);
      cols_b     <= CW'(8);
      accumulate <= 1'b1;
    end else if (write_enable) begin
      case (reg_index)
        mmau_pkg::REG_ROWS_A:     rows_a     <= write_data;
        mmau_pkg::REG_INNER_SIZE: inner_size <= write_data;
        mmau_pkg::REG_COLS_B:     cols_b     <= write_data;
        mmau_pkg::REG_ACCUMULATE: accumulate <= write_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (operation == mmau_pkg::OP_START)) begin
          state_next = S_CRD;
        end
      end
      S_CRD: state_next = S_CLD;
      S_CLD: state_next = S_RD;
      S_RD:  state_next = S_MUL;
      S_MUL: state_next = S_ACC;
      S_ACC: state_next = (p_cnt == k_last) ? S_OUT : S_RD;
      S_OUT: begin
        if (out_load) begin
          state_next = ((i_cnt == m_last) && (j_cnt == n_last)) ? S_IDLE : S_CRD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      i_cnt     <= '0;
      j_cnt     <= '0;
      p_cnt     <= '0;
      m_last    <= '0;
      k_last    <= '0;
      n_last    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && (operation == mmau_pkg::OP_START)) begin
        i_cnt  <= '0;
        j_cnt  <= '0;
        p_cnt  <= '0;
        m_last <= dim_last(rows_a);
        k_last <= dim_last(inner_size);
        n_last <= dim_last(cols_b);
      end
      if (state == S_CLD) begin
        p_cnt <= '0;
      end else if ((state == S_ACC) && (p_cnt != k_last)) begin
        p_cnt <= p_cnt + IW'(1);
      end
      if (out_load) begin
        if (i_cnt == m_last) begin
          i_cnt <= '0;
          j_cnt <= j_cnt + IW'(1);
        end else begin
          i_cnt <= i_cnt + IW'(1);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row   <= i_cnt;
      out_col   <= j_cnt;
      out_value <= mac_res;
      saturated <= mac_sat;
      last      <= (i_cnt == m_last) && (j_cnt == n_last);
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> ((i_cnt <= m_last) && (j_cnt <= n_last) && (p_cnt <= k_last)))
    else $error("run counter beyond its size");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_OUT))
    else $error("result raised outside the result step");

  a_c_write_src: assert property (@(posedge clk) disable iff (rst)
    (c_we && (state != S_IDLE)) |-> (state == S_OUT))
    else $error("C store written mid-run outside write-back");

endmodule

// ===== tb/mmau_checker.sv =====
`timescale 1ns / 1ps

module mmau_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [mmau_pkg::OP_W-1:0]          operation,
  input  logic [mmau_pkg::IDX_W-1:0]         row_index,
  input  logic [mmau_pkg::IDX_W-1:0]         col_index,
  input  logic signed [mmau_pkg::DATA_W-1:0] element_value,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [mmau_pkg::IDX_W-1:0]         out_row,
  input  logic [mmau_pkg::IDX_W-1:0]         out_col,
  input  logic signed [mmau_pkg::DATA_W-1:0] out_value,
  input  logic                               saturated,
  input  logic                               last,
  input  logic                               write_enable,
  input  logic [mmau_pkg::CFG_IDX_W-1:0]     reg_index,
  input  logic [mmau_pkg::CFG_W-1:0]         write_data,
  output int                                 mismatches,
  output int                                 elements_due
);

  localparam int DIM    = mmau_pkg::MAX_DIM_DEF;
  localparam int FRAC   = mmau_pkg::FRAC_BITS_DEF;
  localparam int IDX_W  = mmau_pkg::IDX_W;
  localparam int DATA_W = mmau_pkg::DATA_W;
  localparam int CFG_W  = mmau_pkg::CFG_W;
  localparam logic signed [95:0] Q_MAX = 96'sd2147483647;
  localparam logic signed [95:0] Q_MIN = -96'sd2147483648;

  typedef struct packed {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
    logic              sat;
    logic              last;
  } c_element_t;

  logic [DATA_W-1:0] a_mem [DIM][DIM];
  logic [DATA_W-1:0] b_mem [DIM][DIM];
  logic [DATA_W-1:0] c_mem [DIM][DIM];
  logic [CFG_W-1:0]  rows_reg;
  logic [CFG_W-1:0]  inner_reg;
  logic [CFG_W-1:0]  cols_reg;
  logic              acc_reg;
  c_element_t        c_due_q [$];

  function automatic int clamp_dim(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  task automatic multiply_into_c();
    int m;
    int k;
    int n;
    logic signed [95:0]       total;
    logic signed [63:0]       prod;
    logic signed [DATA_W-1:0] av;
    logic signed [DATA_W-1:0] bv;
    logic signed [DATA_W-1:0] cv;
    c_element_t               e;
    m = clamp_dim(rows_reg);
    k = clamp_dim(inner_reg);
    n = clamp_dim(cols_reg);
    for (int j = 0; j < n; j++) begin
      for (int i = 0; i < m; i++) begin
        total = '0;
        if (acc_reg) begin
          cv = c_mem[i][j];
          total = cv;
          total = total <<< FRAC;
        end
        for (int p = 0; p < k; p++) begin
          av = a_mem[i][p];
          bv = b_mem[p][j];
          prod = av * bv;
          total = total + prod;
        end
        total = total >>> FRAC;
        e.row = IDX_W'(i);
        e.col = IDX_W'(j);
        if (total > Q_MAX) begin
          e.value = 32'h7FFF_FFFF;
          e.sat = 1'b1;
        end else if (total < Q_MIN) begin
          e.value = 32'h8000_0000;
          e.sat = 1'b1;
        end else begin
          e.value = total[DATA_W-1:0];
          e.sat = 1'b0;
        end
        e.last = (i == m - 1) && (j == n - 1);
        c_mem[i][j] = e.value;
        c_due_q.push_back(e);
      end
    end
  endtask

  task automatic flag_element(string what, c_element_t want, c_element_t got);
    if (mismatches < 10)
      $display("mmau_checker: %s at %0t: exp r%0d c%0d %h s%b l%b, got r%0d c%0d %h s%b l%b",
               what, $time, want.row, want.col, want.value, want.sat, want.last,
               got.row, got.col, got.value, got.sat, got.last);
    mismatches++;
  endtask

  always @(posedge clk) begin
    c_element_t got;
    c_element_t want;
    if (rst) begin
      foreach (a_mem[i, j]) begin
        a_mem[i][j] = '0;
        b_mem[i][j] = '0;
        c_mem[i][j] = '0;
      end
      rows_reg = 4'd8;
      inner_reg = 4'd8;
      cols_reg = 4'd8;
      acc_reg = 1'b1;
      c_due_q.delete();
      mismatches = 0;
    end else begin
      if (write_enable) begin
        case (reg_index)
          mmau_pkg::REG_ROWS_A:     rows_reg = write_data;
          mmau_pkg::REG_INNER_SIZE: inner_reg = write_data;
          mmau_pkg::REG_COLS_B:     cols_reg = write_data;
          mmau_pkg::REG_ACCUMULATE: acc_reg = write_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (operation)
          mmau_pkg::OP_LOAD_A: a_mem[row_index][col_index] = element_value;
          mmau_pkg::OP_LOAD_B: b_mem[row_index][col_index] = element_value;
          mmau_pkg::OP_LOAD_C: c_mem[row_index][col_index] = element_value;
          mmau_pkg::OP_START:  multiply_into_c();
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = {out_row, out_col, out_value, saturated, last};
        if (c_due_q.size() == 0) begin
          flag_element("unexpected element", '0, got);
        end else begin
          want = c_due_q.pop_front();
          if (got !== want) flag_element("element mismatch", want, got);
        end
      end
    end
    elements_due <= c_due_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT        = 1_000_000;
  localparam int RANDOM_ITEMS = 150;
  localparam int OP_W         = mmau_pkg::OP_W;
  localparam int IDX_W        = mmau_pkg::IDX_W;
  localparam int DATA_W       = mmau_pkg::DATA_W;
  localparam int CFG_W        = mmau_pkg::CFG_W;
  localparam int CFG_IDX_W    = mmau_pkg::CFG_IDX_W;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [OP_W-1:0]          operation;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [DATA_W-1:0] element_value;
  logic                     out_valid;
  logic                     out_ready;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [DATA_W-1:0] out_value;
  logic                     saturated;
  logic                     last;
  logic                     write_enable;
  logic [CFG_IDX_W-1:0]     reg_index;
  logic [CFG_W-1:0]         write_data;
  int                       mismatches;
  int                       elements_due;
  int                       cycles;
  int                       items_sent;
  int                       dim_m;
  int                       dim_k;
  int                       dim_n;
  bit                       calm;

  matrix_multiply_accumulate_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .row_index(row_index), .col_index(col_index),
    .element_value(element_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_row(out_row), .out_col(out_col), .out_value(out_value),
    .saturated(saturated), .last(last),
    .write_enable(write_enable), .reg_index(reg_index), .write_data(write_data)
  );

  mmau_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .row_index(row_index), .col_index(col_index),
    .element_value(element_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_row(out_row), .out_col(out_col), .out_value(out_value),
    .saturated(saturated), .last(last),
    .write_enable(write_enable), .reg_index(reg_index), .write_data(write_data),
    .mismatches(mismatches), .elements_due(elements_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles <= LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: FAIL");
    $finish;
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int eff_dim(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > mmau_pkg::MAX_DIM_DEF) return mmau_pkg::MAX_DIM_DEF;
    return int'(v);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return v;
      3: return DATA_W'($urandom_range(0, 15)) - 32'd8;
      default: return {{12{v[19]}}, v[19:0]};
    endcase
  endfunction

  // hold valid and payload until the transaction is taken
  task automatic send(logic [OP_W-1:0] op, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                      logic [DATA_W-1:0] value);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    row_index <= row;
    col_index <= col;
    element_value <= value;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (elements_due != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic configure(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] inner,
                           logic [CFG_W-1:0] cols, logic [CFG_W-1:0] acc);
    write_enable <= 1'b1;
    reg_index <= mmau_pkg::REG_ROWS_A;
    write_data <= rows;
    @(posedge clk);
    reg_index <= mmau_pkg::REG_INNER_SIZE;
    write_data <= inner;
    @(posedge clk);
    reg_index <= mmau_pkg::REG_COLS_B;
    write_data <= cols;
    @(posedge clk);
    reg_index <= mmau_pkg::REG_ACCUMULATE;
    write_data <= acc;
    @(posedge clk);
    write_enable <= 1'b0;
    dim_m = eff_dim(rows);
    dim_k = eff_dim(inner);
    dim_n = eff_dim(cols);
  endtask

  task automatic random_phase();
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] inner;
    logic [CFG_W-1:0] cols;
    if ($urandom_range(0, 5) == 0) begin
      rows = CFG_W'($urandom_range(8, 15));
      inner = CFG_W'($urandom_range(8, 15));
      cols = CFG_W'($urandom_range(8, 15));
    end else begin
      rows = CFG_W'($urandom_range(0, 4));
      inner = CFG_W'($urandom_range(0, 4));
      cols = CFG_W'($urandom_range(0, 4));
    end
    calm = ($urandom_range(0, 3) == 0);
    configure(rows, inner, cols, CFG_W'($urandom));
  endtask

  task automatic load_and_start();
    int sel;
    logic [OP_W-1:0] op;
    repeat ($urandom_range(2, 10)) begin
      sel = $urandom_range(0, 9);
      if (sel < 4)
        send(mmau_pkg::OP_LOAD_A, IDX_W'($urandom_range(0, dim_m - 1)),
             IDX_W'($urandom_range(0, dim_k - 1)), pick_value());
      else if (sel < 7)
        send(mmau_pkg::OP_LOAD_B, IDX_W'($urandom_range(0, dim_k - 1)),
             IDX_W'($urandom_range(0, dim_n - 1)), pick_value());
      else if (sel < 9)
        send(mmau_pkg::OP_LOAD_C, IDX_W'($urandom_range(0, dim_m - 1)),
             IDX_W'($urandom_range(0, dim_n - 1)), pick_value());
      else begin
        case ($urandom_range(0, 2))
          0: op = mmau_pkg::OP_LOAD_A;
          1: op = mmau_pkg::OP_LOAD_B;
          default: op = mmau_pkg::OP_LOAD_C;
        endcase
        send(op, IDX_W'($urandom), IDX_W'($urandom), pick_value());
      end
    end
    send(mmau_pkg::OP_START, IDX_W'($urandom), IDX_W'($urandom), DATA_W'($urandom));
  endtask

  initial begin
    int hold;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) hold = idle_cycles();
      end
    end
  end

  initial begin
    int start_count;
    rst <= 1'b1;
    in_valid <= 1'b0;
    operation <= mmau_pkg::OP_LOAD_A;
    row_index <= '0;
    col_index <= '0;
    element_value <= '0;
    write_enable <= 1'b0;
    reg_index <= mmau_pkg::REG_ROWS_A;
    write_data <= '0;
    calm = 1'b0;
    items_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset sizes and cleared stores
    send(mmau_pkg::OP_START, '0, '0, '0);
    drain();

    // saturation both ways, zeroing mode
    configure(4'd2, 4'd2, 4'd2, 4'd0);
    send(mmau_pkg::OP_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
    send(mmau_pkg::OP_LOAD_A, 3'd0, 3'd1, 32'h7FFF_FFFF);
    send(mmau_pkg::OP_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF);
    send(mmau_pkg::OP_LOAD_B, 3'd1, 3'd0, 32'h7FFF_FFFF);
    send(mmau_pkg::OP_LOAD_A, 3'd1, 3'd0, 32'h8000_0000);
    send(mmau_pkg::OP_LOAD_A, 3'd1, 3'd1, 32'hFFFF_FFFF);
    send(mmau_pkg::OP_LOAD_B, 3'd0, 3'd1, 32'h0000_0001);
    send(mmau_pkg::OP_LOAD_B, 3'd1, 3'd1, 32'h8000_0000);
    send(mmau_pkg::OP_LOAD_C, 3'd0, 3'd0, 32'h1234_5678);
    send(mmau_pkg::OP_LOAD_C, 3'd7, 3'd7, 32'h0001_0000);
    send(mmau_pkg::OP_START, 3'd7, 3'd7, 32'hFFFF_FFFF);
    drain();

    // floor on a negative sum, zero size clamps up
    configure(4'd0, 4'd1, 4'd0, 4'd1);
    send(mmau_pkg::OP_LOAD_C, 3'd0, 3'd0, 32'hFFFF_FFFF);
    send(mmau_pkg::OP_LOAD_A, 3'd0, 3'd0, 32'hFFFF_FFFF);
    send(mmau_pkg::OP_LOAD_B, 3'd0, 3'd0, 32'h0000_0001);
    send(mmau_pkg::OP_START, 3'd0, 3'd0, 32'h0);
    drain();

    // oversize registers clamp down, accumulate twice
    configure(4'd1, 4'd15, 4'd9, 4'd1);
    send(mmau_pkg::OP_LOAD_B, 3'd7, 3'd7, 32'h0002_0000);
    send(mmau_pkg::OP_START, 3'd0, 3'd0, 32'h0);
    send(mmau_pkg::OP_START, 3'd5, 3'd2, 32'hA5A5_A5A5);
    drain();

    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      random_phase();
      repeat ($urandom_range(1, 3)) load_and_start();
      drain();
    end
    calm = 1'b0;

    repeat (20) @(posedge clk);
    if (mismatches == 0 && elements_due == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mmau_pkg.sv
hw/rtl/mmau_ram.sv
hw/rtl/mmau_store.sv
hw/rtl/mmau_mac.sv
hw/rtl/matrix_multiply_accumulate_unit.sv
tb/mmau_checker.sv
tb/tb.sv
